@@ rtl/core/pud_pkg.sv @@
// Shared types and constants for the permutation unrank decoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pud_pkg;

    // Fixed widths of the channel fields.
    localparam int RANK_W  = 62;
    localparam int COUNT_W = 5;
    localparam int FIELD_W = 5;

    // Width of one mixed-radix digit held by a conversion cell (radix up to 20).
    localparam int DIGIT_W = 5;

    // Link between two neighboring conversion cells: a qualified carry bit.
    typedef struct packed {
        logic valid;
        logic carry;
    } t_cell_link;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_READ,
        ST_WRITE,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ rtl/core/pud_if.sv @@
// Channel interfaces of the permutation unrank decoder: request and result streams.
// Depends on pud_pkg for the field widths.
`default_nettype none

interface pud_in_if
    import pud_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [RANK_W-1:0]  rank;
    logic [COUNT_W-1:0] count;

    modport source (output valid, output rank, output count, input ready);
    modport sink   (input valid, input rank, input count, output ready);
endinterface

interface pud_out_if
    import pud_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] position;
    logic [FIELD_W-1:0] element;
    logic               last;

    modport source (output valid, output position, output element, output last, input ready);
    modport sink   (input valid, input position, input element, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pud_cell.sv @@
// One mixed-radix conversion cell: holds a single digit and doubles it each cycle its input link is valid.
// Depends on pud_pkg for the digit width and the cell link type.
`default_nettype none

module pud_cell
    import pud_pkg::*;
#(
    parameter int RADIX = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  t_cell_link         i_link,
    output t_cell_link         o_link,
    output logic [DIGIT_W-1:0] o_digit
);

    localparam logic [DIGIT_W:0] RADIX_V = (DIGIT_W + 1)'(RADIX);

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    t_cell_link         r_link;
    t_cell_link         n_link;
    logic [DIGIT_W:0]   w_sum;

    // Doubling a digit and adding a carry stays below twice the radix, so a
    // single compare and subtract reduces it and the carry out is one bit.
    always_comb begin
        w_sum        = {r_digit, i_link.carry};
        n_link.valid = i_link.valid;
        n_link.carry = 1'b0;
        n_digit      = r_digit;
        if (i_link.valid) begin
            if (w_sum >= RADIX_V) begin
                n_digit      = DIGIT_W'(w_sum - RADIX_V);
                n_link.carry = 1'b1;
            end else begin
                n_digit = w_sum[DIGIT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_clear) begin
            r_digit <= '0;
        end else begin
            r_digit <= n_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link <= '0;
        end else begin
            r_link <= n_link;
        end
    end

    assign o_link  = r_link;
    assign o_digit = r_digit;

endmodule

`default_nettype wire

@@ rtl/core/pud_digit_chain.sv @@
// Row of conversion cells that turns a bit-serial rank into factoradic digits.
// Depends on pud_pkg and pud_cell.
`default_nettype none

module pud_digit_chain
    import pud_pkg::*;
#(
    parameter int MAX_ELEMENTS = 20
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_clear,
    input  t_cell_link         i_link,
    output t_cell_link         o_tail,
    output logic [DIGIT_W-1:0] o_digits [MAX_ELEMENTS]
);

    // w_link[k] feeds the cell of radix k+1; the last entry is the tail.
    t_cell_link w_link [1:MAX_ELEMENTS];

    assign w_link[1]   = i_link;
    assign o_digits[0] = '0;

    for (genvar k = 1; k < MAX_ELEMENTS; k++) begin : g_cell
        pud_cell #(
            .RADIX (k + 1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clear (i_clear),
            .i_link  (w_link[k]),
            .o_link  (w_link[k+1]),
            .o_digit (o_digits[k])
        );
    end

    assign o_tail = w_link[MAX_ELEMENTS];

endmodule

`default_nettype wire

@@ rtl/core/permutation_unrank_decoder_core.sv @@
// Permutation unrank decoder. A request transaction carries a rank and an element
// count (values above MAX_ELEMENTS act as MAX_ELEMENTS); the block answers with one
// result transaction per element, positions 0 to count-1 in order, the final one
// with last set, and a count of zero yields no result at all. Only rank modulo
// count! matters. One request is in work at a time: after acceptance the rank is
// shifted MSB first into a row of MAX_ELEMENTS-1 digit cells at one bit per cycle;
// the Fisher-Yates replay then reads and writes the pool memory for each element,
// and the results leave at one per cycle while the sink is ready. Depends on
// pud_pkg, pud_if and pud_digit_chain.
`default_nettype none

module permutation_unrank_decoder_core
    import pud_pkg::*;
#(
    parameter int MAX_ELEMENTS = 20
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    pud_in_if.sink        i_req,
    pud_out_if.source     o_rsp
);

    localparam int IDX_W  = $clog2(MAX_ELEMENTS);
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int FEED_W = $clog2(RANK_W + 1);

    // Control state.
    t_state             r_state;
    t_state             n_state;
    logic [FEED_W-1:0]  r_feed_cnt;
    logic [IDX_W-1:0]   r_step;
    logic [IDX_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_count;
    logic               r_sel_valid;
    logic               r_top_valid;
    logic [MAX_ELEMENTS-1:0] r_pool_valid;

    // Payload registers.
    logic [RANK_W-1:0]  r_rank_sh;
    logic [IDX_W-1:0]   r_sel_addr;
    logic [IDX_W-1:0]   r_rd_sel;
    logic [IDX_W-1:0]   r_rd_top;
    logic [IDX_W-1:0]   r_res [MAX_ELEMENTS];

    // The pool memory: one write port, two registered read ports. An entry whose
    // valid bit is clear is read as its own index.
    logic [IDX_W-1:0]   mem_pool [MAX_ELEMENTS];

    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_last;
    logic               w_feeding;
    logic [CNT_W-1:0]   w_count_sat;
    logic [IDX_W-1:0]   w_sel_addr;
    logic [IDX_W-1:0]   w_elem;
    logic [IDX_W-1:0]   w_top;
    t_cell_link         w_feed;
    t_cell_link         w_tail;
    logic [DIGIT_W-1:0] w_digits [MAX_ELEMENTS];

    assign w_in_acc  = i_req.valid && i_req.ready;
    assign w_out_acc = o_rsp.valid && o_rsp.ready;

    // Counts above the row length act as the full row.
    assign w_count_sat = (i_req.count > COUNT_W'(MAX_ELEMENTS)) ?
                         CNT_W'(MAX_ELEMENTS) : i_req.count[CNT_W-1:0];

    // The rank enters the chain most significant bit first; each cell doubles
    // its digit and adds the carry of its lower neighbor, so after all bits
    // have rippled through, cell k holds (rank / k!) mod (k+1). The carry out
    // of the top cell is dropped, which keeps the value modulo MAX_ELEMENTS!.
    assign w_feeding    = (r_state == ST_CONVERT) && (r_feed_cnt != FEED_W'(RANK_W));
    assign w_feed.valid = w_feeding;
    assign w_feed.carry = r_rank_sh[RANK_W-1];

    pud_digit_chain #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_chain (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (w_in_acc),
        .i_link   (w_feed),
        .o_tail   (w_tail),
        .o_digits (w_digits)
    );

    // A digit never exceeds its index, so it fits the pool address.
    assign w_sel_addr = w_digits[r_step][IDX_W-1:0];

    // Fisher-Yates replay: element i takes pool[digit i], and that slot then
    // takes pool[i]. Unwritten slots read as their own index.
    assign w_elem = r_sel_valid ? r_rd_sel : r_sel_addr;
    assign w_top  = r_top_valid ? r_rd_top : r_step;

    assign w_last = (CNT_W'(r_pos) == (r_count - CNT_W'(1)));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_req.count != '0)) begin
                    n_state = ST_CONVERT;
                end
            end
            ST_CONVERT: begin
                // The tail link drops once the top cell has taken the last bit.
                if (!w_feeding && !w_tail.valid) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                if (r_step == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_EMIT: begin
                if (w_out_acc && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Handshake and result outputs.
    always_comb begin
        i_req.ready    = (r_state == ST_IDLE);
        o_rsp.valid    = (r_state == ST_EMIT);
        o_rsp.position = FIELD_W'(r_pos);
        o_rsp.element  = FIELD_W'(r_res[r_pos]);
        o_rsp.last     = w_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_feed_cnt   <= '0;
            r_step       <= '0;
            r_pos        <= '0;
            r_count      <= '0;
            r_sel_valid  <= 1'b0;
            r_top_valid  <= 1'b0;
            r_pool_valid <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_feed_cnt   <= '0;
                r_count      <= w_count_sat;
                r_step       <= IDX_W'(w_count_sat - CNT_W'(1));
                r_pos        <= '0;
                r_pool_valid <= '0;
            end
            if (w_feeding) begin
                r_feed_cnt <= r_feed_cnt + FEED_W'(1);
            end
            if (r_state == ST_READ) begin
                r_sel_valid <= r_pool_valid[w_sel_addr];
                r_top_valid <= r_pool_valid[r_step];
            end
            if (r_state == ST_WRITE) begin
                r_pool_valid[r_sel_addr] <= 1'b1;
                if (r_step != '0) begin
                    r_step <= r_step - IDX_W'(1);
                end
            end
            if (w_out_acc && !w_last) begin
                r_pos <= r_pos + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_rank_sh <= i_req.rank;
        end else if (w_feeding) begin
            r_rank_sh <= {r_rank_sh[RANK_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_sel_addr <= w_sel_addr;
            r_rd_sel   <= mem_pool[w_sel_addr];
            r_rd_top   <= mem_pool[r_step];
        end
        if (r_state == ST_WRITE) begin
            mem_pool[r_sel_addr] <= w_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WRITE) begin
            r_res[r_step] <= w_elem;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/pud_checker.sv @@
// Port-level checker for the permutation unrank decoder, bound to the top level.
// Depends on pud_pkg for the field widths.
`default_nettype none

module pud_checker
    import pud_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_ready,
    input wire logic               i_out_valid,
    input wire logic               i_out_ready,
    input wire logic [FIELD_W-1:0] i_position,
    input wire logic [FIELD_W-1:0] i_element,
    input wire logic               i_last
);

    logic w_out_acc;

    assign w_out_acc = i_out_valid && i_out_ready;

    // No result is offered in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // One request at a time: no new transaction is taken while results are pending.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("request accepted while results are pending");

    // After a result that is not the last one, the next result follows at once
    // with the next position.
    a_next_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && !i_last |=> i_out_valid && (i_position == $past(i_position) + 1'b1))
        else $error("result positions are not consecutive");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_position)
            && $stable(i_element) && $stable(i_last))
        else $error("stalled result changed");

endmodule

bind permutation_unrank_decoder_core pud_checker u_pud_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_position  (o_rsp.position),
    .i_element   (o_rsp.element),
    .i_last      (o_rsp.last)
);

`default_nettype wire
